// ----- rtl/vol2col_address_walker_macros.svh -----
// Assertion macros for the vol2col address walker checker.
// Stand-alone; taken in by the checker file.
`ifndef VOL2COL_ADDRESS_WALKER_MACROS_SVH
`define VOL2COL_ADDRESS_WALKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define V2C_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define V2C_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/v2c_pkg.sv -----
// Shared types and constants for the vol2col address walker.
// No dependencies.
package v2c_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;
	localparam int KREG_W     = 12;
	localparam int DREG_W     = 30;
	localparam int PREG_W     = 10;
	localparam int DEST_W     = 32;
	localparam int SRC_W      = 32;

	localparam logic [KREG_W-1:0] KERNEL_SIZES_RST = 12'd273;
	localparam logic [KREG_W-1:0] STRIDES_RST      = 12'd273;
	localparam logic [KREG_W-1:0] PADS_RST         = 12'd0;
	localparam logic [DREG_W-1:0] INPUT_DIMS_RST   = 30'd1049601;
	localparam logic [DREG_W-1:0] OUTPUT_DIMS_RST  = 30'd1049601;
	localparam logic [PREG_W-1:0] PLANE_COUNT_RST  = 10'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_SIZES = 3'd0,
		REG_STRIDES      = 3'd1,
		REG_PADS         = 3'd2,
		REG_INPUT_DIMS   = 3'd3,
		REG_OUTPUT_DIMS  = 3'd4,
		REG_PLANE_COUNT  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [KREG_W-1:0] kernel_sizes;
		logic [KREG_W-1:0] strides;
		logic [KREG_W-1:0] pads;
		logic [DREG_W-1:0] input_dims;
		logic [DREG_W-1:0] output_dims;
		logic [PREG_W-1:0] plane_count;
	} cfg_regs_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COORD,
		ST_ACC,
		ST_DONE
	} state_t;

	// Horner steps of the address: depth, height, width
	typedef enum logic [1:0] {
		STEP_D,
		STEP_H,
		STEP_W
	} step_t;

	typedef struct packed {
		logic  accept;
		logic  coord_en;
		logic  acc_en;
		step_t step;
		logic  out_load;
	} ctrl_cmd_t;

endpackage

// ----- rtl/v2c_in_if.sv -----
// Input channel of the vol2col address walker: valid, ready, restart.
// No dependencies.
interface v2c_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// ----- rtl/v2c_out_if.sv -----
// Output channel of the vol2col address walker: one column element per beat.
// No dependencies.
interface v2c_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] dest_index;
	logic [31:0] source_address;
	logic        is_padding;
	logic        last;

	modport source (output valid, output dest_index, output source_address,
		output is_padding, output last, input ready);
	modport sink (input valid, input dest_index, input source_address,
		input is_padding, input last, output ready);
endinterface

// ----- rtl/vol2col_address_walker.sv -----
// Top level of the vol2col (3D im2col) address walker.
// Depends on v2c_pkg, v2c_in_if, v2c_out_if, v2c_cfg, v2c_ctrl, v2c_dpath.
//
// Use:
//   in_ch  : one beat per column element asked for; restart=1 sends the walk
//            back to element 0 before this element is generated.
//   out_ch : one beat per input beat, carrying dest_index, source_address
//            (0 when is_padding), is_padding and last on the final element.
//   cfg_*  : register writes, taken at any edge with cfg_write high; write
//            only while no element is in flight. Indices 6 and 7 are ignored.
// Sequence: an element is taken in, its padded coordinates registered, the
//   voxel address built in three multiply-add steps on one shared
//   multiplier, then the result loaded into the output register. A new
//   element is taken only once the previous result has been loaded.
// A waiting result does not block the next input beat; that element stalls
//   before the output load until the receiver takes the waiting one.
// Reset: counters at element 0, registers at their defaults, no output valid.
module vol2col_address_walker #(
	parameter int DIM_BITS    = 10,
	parameter int KERNEL_BITS = 4,
	parameter int ADDR_BITS   = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [v2c_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [v2c_pkg::CFG_DATA_W-1:0]   cfg_data,
	v2c_in_if.sink                           in_ch,
	v2c_out_if.source                        out_ch
);
	import v2c_pkg::*;

	cfg_regs_t regs;
	ctrl_cmd_t cmd;

	v2c_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	v2c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	v2c_dpath #(
		.DIM_BITS    (DIM_BITS),
		.KERNEL_BITS (KERNEL_BITS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (regs),
		.cmd            (cmd),
		.restart        (in_ch.restart),
		.dest_index     (out_ch.dest_index),
		.source_address (out_ch.source_address),
		.is_padding     (out_ch.is_padding),
		.last           (out_ch.last)
	);
endmodule

// ----- rtl/v2c_cfg.sv -----
// Configuration register file of the vol2col address walker.
// Depends on v2c_pkg.
module v2c_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [v2c_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [v2c_pkg::CFG_DATA_W-1:0]       cfg_data,
	output v2c_pkg::cfg_regs_t                   regs
);
	import v2c_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kernel_sizes <= KERNEL_SIZES_RST;
			regs_q.strides      <= STRIDES_RST;
			regs_q.pads         <= PADS_RST;
			regs_q.input_dims   <= INPUT_DIMS_RST;
			regs_q.output_dims  <= OUTPUT_DIMS_RST;
			regs_q.plane_count  <= PLANE_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KERNEL_SIZES: regs_q.kernel_sizes <= cfg_data[KREG_W-1:0];
				REG_STRIDES:      regs_q.strides      <= cfg_data[KREG_W-1:0];
				REG_PADS:         regs_q.pads         <= cfg_data[KREG_W-1:0];
				REG_INPUT_DIMS:   regs_q.input_dims   <= cfg_data[DREG_W-1:0];
				REG_OUTPUT_DIMS:  regs_q.output_dims  <= cfg_data[DREG_W-1:0];
				REG_PLANE_COUNT:  regs_q.plane_count  <= cfg_data[PREG_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;
endmodule

// ----- rtl/v2c_ctrl.sv -----
// Sequencer of the vol2col address walker: accept, coordinate, three
// address steps, then hand-off to the output register. Depends on v2c_pkg.
module v2c_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output v2c_pkg::ctrl_cmd_t   cmd
);
	import v2c_pkg::*;

	state_t state_q, state_d;
	step_t  step_q;
	logic   out_full_q;
	logic   accept;
	logic   load;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign load   = (state_q == ST_DONE) && (!out_full_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_COORD;
			ST_COORD: state_d = ST_ACC;
			ST_ACC:   if (step_q == STEP_W) state_d = ST_DONE;
			ST_DONE:  if (load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		out_valid    = out_full_q;
		cmd.accept   = accept;
		cmd.coord_en = (state_q == ST_COORD);
		cmd.acc_en   = (state_q == ST_ACC);
		cmd.step     = step_q;
		cmd.out_load = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= STEP_D;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_COORD) begin
				step_q <= STEP_D;
			end else if (state_q == ST_ACC) begin
				case (step_q)
					STEP_D:  step_q <= STEP_H;
					STEP_H:  step_q <= STEP_W;
					default: step_q <= STEP_D;
				endcase
			end
			if (load) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/v2c_dpath.sv -----
// Datapath of the vol2col address walker: walk counters, padded coordinates,
// shared multiply-add for the voxel address, output register. Depends on v2c_pkg.
module v2c_dpath #(
	parameter int DIM_BITS    = 10,
	parameter int KERNEL_BITS = 4,
	parameter int ADDR_BITS   = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  v2c_pkg::cfg_regs_t              cfg,
	input  v2c_pkg::ctrl_cmd_t              cmd,
	input  logic                            restart,
	output logic [v2c_pkg::DEST_W-1:0]      dest_index,
	output logic [v2c_pkg::SRC_W-1:0]       source_address,
	output logic                            is_padding,
	output logic                            last
);
	import v2c_pkg::*;

	localparam int D   = DIM_BITS;
	localparam int K   = KERNEL_BITS;
	localparam int A   = ADDR_BITS;
	localparam int KV  = (3 * K > KREG_W) ? 3 * K : KREG_W;
	localparam int DV  = (3 * D > DREG_W) ? 3 * D : DREG_W;
	localparam int PV  = (D > PREG_W) ? D : PREG_W;
	localparam int SV  = (A > SRC_W) ? A : SRC_W;
	localparam int CW  = D + K + 2;
	localparam int D1  = D + 1;
	localparam int K1  = K + 1;

	// field decode
	logic [KV-1:0] ks_x, st_x, pd_x;
	logic [DV-1:0] id_x, od_x;
	logic [PV-1:0] pc_x;
	logic [K-1:0]  kw_sz, kh_sz, kd_sz, sw, sh, sd, pw, ph, pd;
	logic [D-1:0]  iw, ih, idp, ow_sz, oh_sz, od_sz, np;

	assign ks_x  = KV'(cfg.kernel_sizes);
	assign st_x  = KV'(cfg.strides);
	assign pd_x  = KV'(cfg.pads);
	assign id_x  = DV'(cfg.input_dims);
	assign od_x  = DV'(cfg.output_dims);
	assign pc_x  = PV'(cfg.plane_count);
	assign kw_sz = ks_x[K-1:0];
	assign kh_sz = ks_x[2*K-1:K];
	assign kd_sz = ks_x[3*K-1:2*K];
	assign sw    = st_x[K-1:0];
	assign sh    = st_x[2*K-1:K];
	assign sd    = st_x[3*K-1:2*K];
	assign pw    = pd_x[K-1:0];
	assign ph    = pd_x[2*K-1:K];
	assign pd    = pd_x[3*K-1:2*K];
	assign iw    = id_x[D-1:0];
	assign ih    = id_x[2*D-1:D];
	assign idp   = id_x[3*D-1:2*D];
	assign ow_sz = od_x[D-1:0];
	assign oh_sz = od_x[2*D-1:D];
	assign od_sz = od_x[3*D-1:2*D];
	assign np    = pc_x[D-1:0];

	// walk counters
	logic [D-1:0]  ow_q, oh_q, od_q, p_q;
	logic [K-1:0]  kw_q, kh_q, kd_q;
	logic [31:0]   elem_q;

	// padded coordinates
	logic [CW-1:0] w_c, h_c, d_c;
	logic          in_w, in_h, in_d;
	logic [D-1:0]  w_q, h_q, d_q;
	logic          inside_q;

	assign w_c = CW'(ow_q) * CW'(sw) - CW'(pw) + CW'(kw_q);
	assign h_c = CW'(oh_q) * CW'(sh) - CW'(ph) + CW'(kh_q);
	assign d_c = CW'(od_q) * CW'(sd) - CW'(pd) + CW'(kd_q);
	assign in_w = !w_c[CW-1] && (w_c < CW'(iw));
	assign in_h = !h_c[CW-1] && (h_c < CW'(ih));
	assign in_d = !d_c[CW-1] && (d_c < CW'(idp));

	// address accumulator: ((p*id + d)*ih + h)*iw + w
	logic [A-1:0] acc_q, prod;
	logic [D-1:0] dim_sel, crd_sel;

	always_comb begin
		case (cmd.step)
			STEP_D: begin
				dim_sel = idp;
				crd_sel = d_q;
			end
			STEP_H: begin
				dim_sel = ih;
				crd_sel = h_q;
			end
			default: begin
				dim_sel = iw;
				crd_sel = w_q;
			end
		endcase
	end

	assign prod = acc_q * A'(dim_sel);

	// end-of-count flags
	logic e_ow, e_oh, e_od, e_kw, e_kh, e_kd, e_p, is_last;

	assign e_ow = (D1'(ow_q) + D1'(1)) >= D1'(ow_sz);
	assign e_oh = (D1'(oh_q) + D1'(1)) >= D1'(oh_sz);
	assign e_od = (D1'(od_q) + D1'(1)) >= D1'(od_sz);
	assign e_kw = (K1'(kw_q) + K1'(1)) >= K1'(kw_sz);
	assign e_kh = (K1'(kh_q) + K1'(1)) >= K1'(kh_sz);
	assign e_kd = (K1'(kd_q) + K1'(1)) >= K1'(kd_sz);
	assign e_p  = (D1'(p_q) + D1'(1)) >= D1'(np);
	assign is_last = e_ow && e_oh && e_od && e_kw && e_kh && e_kd && e_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q   <= '0;
			oh_q   <= '0;
			od_q   <= '0;
			kw_q   <= '0;
			kh_q   <= '0;
			kd_q   <= '0;
			p_q    <= '0;
			elem_q <= '0;
		end else if ((cmd.accept && restart) || (cmd.out_load && is_last)) begin
			ow_q   <= '0;
			oh_q   <= '0;
			od_q   <= '0;
			kw_q   <= '0;
			kh_q   <= '0;
			kd_q   <= '0;
			p_q    <= '0;
			elem_q <= '0;
		end else if (cmd.out_load) begin
			elem_q <= elem_q + 32'd1;
			ow_q   <= e_ow ? '0 : ow_q + D'(1);
			if (e_ow) begin
				oh_q <= e_oh ? '0 : oh_q + D'(1);
			end
			if (e_ow && e_oh) begin
				od_q <= e_od ? '0 : od_q + D'(1);
			end
			if (e_ow && e_oh && e_od) begin
				kw_q <= e_kw ? '0 : kw_q + K'(1);
			end
			if (e_ow && e_oh && e_od && e_kw) begin
				kh_q <= e_kh ? '0 : kh_q + K'(1);
			end
			if (e_ow && e_oh && e_od && e_kw && e_kh) begin
				kd_q <= e_kd ? '0 : kd_q + K'(1);
			end
			if (e_ow && e_oh && e_od && e_kw && e_kh && e_kd) begin
				p_q <= e_p ? '0 : p_q + D'(1);
			end
		end
	end

	// payload registers
	logic [DEST_W-1:0] dest_q;
	logic [SRC_W-1:0]  src_q;
	logic              pad_q;
	logic              last_q;
	logic [SV-1:0]     acc_x;

	assign acc_x = SV'(acc_q);

	always_ff @(posedge clk) begin
		if (cmd.coord_en) begin
			w_q      <= w_c[D-1:0];
			h_q      <= h_c[D-1:0];
			d_q      <= d_c[D-1:0];
			inside_q <= in_w && in_h && in_d;
			acc_q    <= A'(p_q);
		end
		if (cmd.acc_en) begin
			acc_q <= prod + A'(crd_sel);
		end
		if (cmd.out_load) begin
			dest_q <= elem_q;
			src_q  <= inside_q ? acc_x[SRC_W-1:0] : '0;
			pad_q  <= !inside_q;
			last_q <= is_last;
		end
	end

	assign dest_index     = dest_q;
	assign source_address = src_q;
	assign is_padding     = pad_q;
	assign last           = last_q;
endmodule

// ----- rtl/v2c_checker.sv -----
// Port-level checker for the vol2col address walker, bound to the top level.
// Depends on vol2col_address_walker_macros.svh.
`include "vol2col_address_walker_macros.svh"

module v2c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] dest_index,
	input logic [31:0] source_address,
	input logic        is_padding,
	input logic        last
);
	`V2C_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(dest_index) && $stable(source_address) && $stable(is_padding) && $stable(last),
		"stalled output beat changed")
	`V2C_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready,
		"input taken while an element is in flight")
	`V2C_ASSERT_IMP(a_pad_zero, clk, arst_n, out_valid && is_padding, source_address == 32'd0,
		"padding beat with nonzero address")
	`V2C_ASSERT_NXT(a_no_early_out, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid,
		"output valid one cycle after input beat")
endmodule

bind vol2col_address_walker v2c_checker u_v2c_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.dest_index     (out_ch.dest_index),
	.source_address (out_ch.source_address),
	.is_padding     (out_ch.is_padding),
	.last           (out_ch.last)
);

// ----- bench/testbench.sv -----
// Self-checking bench for vol2col_address_walker: a directed table, then random phases.
// The column element stream is predicted in SV and compared beat by beat.
// Depends on v2c_pkg, v2c_in_if, v2c_out_if and the walker RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import v2c_pkg::*;

	localparam int DIM_BITS       = 10;
	localparam int KERNEL_BITS    = 4;
	localparam int ADDR_BITS      = 32;
	localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] ALL_IDX [8] = '{REG_KERNEL_SIZES, REG_STRIDES,
		REG_PADS, REG_INPUT_DIMS, REG_OUTPUT_DIMS, REG_PLANE_COUNT, REG_SPARE_LO,
		REG_SPARE_HI};

	localparam int PHASES          = 16;
	localparam int ITEMS_PER_PHASE = 114;
	localparam int HOLD_PHASE      = 3;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int TAIL_CYCLES     = 20;

	typedef struct packed {
		logic [31:0] dest_index;
		logic [31:0] source_address;
		logic        is_padding;
		logic        last;
	} col_elem_t;

	typedef struct packed {
		logic      known;
		col_elem_t want;
	} beat_plan_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_BEAT,
		ROW_BEAT_KNOWN
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   restart;
		col_elem_t              want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	v2c_in_if  in_ch();
	v2c_out_if out_ch();

	vol2col_address_walker #(
		.DIM_BITS(DIM_BITS),
		.KERNEL_BITS(KERNEL_BITS),
		.ADDR_BITS(ADDR_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// predictor copy of the registers and the walk counters
	logic [KREG_W-1:0]      kern_reg     = KERNEL_SIZES_RST;
	logic [KREG_W-1:0]      stride_reg   = STRIDES_RST;
	logic [KREG_W-1:0]      pad_reg      = PADS_RST;
	logic [DREG_W-1:0]      in_dims_reg  = INPUT_DIMS_RST;
	logic [DREG_W-1:0]      out_dims_reg = OUTPUT_DIMS_RST;
	logic [PREG_W-1:0]      planes_reg   = PLANE_COUNT_RST;
	logic [DIM_BITS-1:0]    ow_c = '0, oh_c = '0, od_c = '0, pl_c = '0;
	logic [KERNEL_BITS-1:0] kw_c = '0, kh_c = '0, kd_c = '0;
	logic [31:0]            elem_c = '0;

	col_elem_t  col_expect [$];
	beat_plan_t beat_plans [$];
	int         fails = 0;
	int         idle_cycles = 0;
	bit         hold_req = 1'b0;

	col_elem_t  seen_e, want_e;
	beat_plan_t plan_e;
	bit         active;

	function automatic bit ends(longint unsigned count, longint unsigned size);
		return count + 1 >= size;
	endfunction

	function automatic void clear_walk();
		ow_c = '0;
		oh_c = '0;
		od_c = '0;
		kw_c = '0;
		kh_c = '0;
		kd_c = '0;
		pl_c = '0;
		elem_c = '0;
	endfunction

	function automatic col_elem_t next_element(bit restart);
		logic [KERNEL_BITS-1:0] kw, kh, kd;
		logic [DIM_BITS-1:0]    ow, oh, od, np;
		longint                 sw, sh, sd, pw, ph, pd, iw, ih, id, w, h, d;
		longint unsigned        hw, dhw, addr;
		bit                     in_vol;
		col_elem_t              r;
		kw = kern_reg[KERNEL_BITS-1:0];
		kh = kern_reg[2*KERNEL_BITS-1:KERNEL_BITS];
		kd = kern_reg[3*KERNEL_BITS-1:2*KERNEL_BITS];
		sw = longint'(stride_reg[KERNEL_BITS-1:0]);
		sh = longint'(stride_reg[2*KERNEL_BITS-1:KERNEL_BITS]);
		sd = longint'(stride_reg[3*KERNEL_BITS-1:2*KERNEL_BITS]);
		pw = longint'(pad_reg[KERNEL_BITS-1:0]);
		ph = longint'(pad_reg[2*KERNEL_BITS-1:KERNEL_BITS]);
		pd = longint'(pad_reg[3*KERNEL_BITS-1:2*KERNEL_BITS]);
		iw = longint'(in_dims_reg[DIM_BITS-1:0]);
		ih = longint'(in_dims_reg[2*DIM_BITS-1:DIM_BITS]);
		id = longint'(in_dims_reg[3*DIM_BITS-1:2*DIM_BITS]);
		ow = out_dims_reg[DIM_BITS-1:0];
		oh = out_dims_reg[2*DIM_BITS-1:DIM_BITS];
		od = out_dims_reg[3*DIM_BITS-1:2*DIM_BITS];
		np = planes_reg[DIM_BITS-1:0];

		if (restart)
			clear_walk();

		w = longint'(ow_c) * sw - pw + longint'(kw_c);
		h = longint'(oh_c) * sh - ph + longint'(kh_c);
		d = longint'(od_c) * sd - pd + longint'(kd_c);
		in_vol = w >= 0 && h >= 0 && d >= 0 && w < iw && h < ih && d < id;

		r.dest_index = elem_c;
		r.source_address = '0;
		if (in_vol) begin
			hw = ih * iw;
			dhw = hw * id;
			addr = longint'(pl_c) * dhw + d * hw + h * iw + w;
			addr = addr & ADDR_MASK;
			r.source_address = addr[31:0];
		end
		r.is_padding = !in_vol;
		r.last = ends(ow_c, ow) && ends(oh_c, oh) && ends(od_c, od) && ends(kw_c, kw) &&
			ends(kh_c, kh) && ends(kd_c, kd) && ends(pl_c, np);

		if (r.last) begin
			clear_walk();
		end else begin
			elem_c = elem_c + 32'd1;
			if (ends(ow_c, ow)) begin
				ow_c = '0;
				if (ends(oh_c, oh)) begin
					oh_c = '0;
					if (ends(od_c, od)) begin
						od_c = '0;
						if (ends(kw_c, kw)) begin
							kw_c = '0;
							if (ends(kh_c, kh)) begin
								kh_c = '0;
								if (ends(kd_c, kd)) begin
									kd_c = '0;
									pl_c = ends(pl_c, np) ? '0 : pl_c + 1'b1;
								end else begin
									kd_c = kd_c + 1'b1;
								end
							end else begin
								kh_c = kh_c + 1'b1;
							end
						end else begin
							kw_c = kw_c + 1'b1;
						end
					end else begin
						od_c = od_c + 1'b1;
					end
				end else begin
					oh_c = oh_c + 1'b1;
				end
			end else begin
				ow_c = ow_c + 1'b1;
			end
		end
		return r;
	endfunction

	task automatic flag(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fails++;
	endtask

	// directed table rows
	function automatic stim_row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		return '{ROW_WRITE, idx, data, 1'b0, '0};
	endfunction

	function automatic stim_row_t beat(logic rst);
		return '{ROW_BEAT, REG_KERNEL_SIZES, '0, rst, '0};
	endfunction

	function automatic stim_row_t known(logic rst, logic [31:0] dest, logic [31:0] src,
		logic pad, logic last);
		return '{ROW_BEAT_KNOWN, REG_KERNEL_SIZES, '0, rst, '{dest, src, pad, last}};
	endfunction

	function automatic logic [KERNEL_BITS-1:0] small_k(int hi);
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			default: return KERNEL_BITS'($urandom_range(1, hi));
		endcase
	endfunction

	function automatic logic [KERNEL_BITS-1:0] pad_field();
		return ($urandom_range(0, 9) == 0) ? '1 : KERNEL_BITS'($urandom_range(0, 2));
	endfunction

	function automatic logic [DIM_BITS-1:0] small_d(int hi);
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			default: return DIM_BITS'($urandom_range(1, hi));
		endcase
	endfunction

	task automatic send_beat(logic rst, logic is_known, col_elem_t want);
		beat_plans.push_back('{is_known, want});
		in_ch.valid <= 1'b1;
		in_ch.restart <= rst;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (col_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: own stall pattern, one long hold-off on request
	initial begin
		logic [15:0] stall_mask;
		out_ch.ready = 1'b0;
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				case ($urandom_range(0, 3))
					0: stall_mask = '1;
					1: stall_mask = 16'($urandom);
					default: stall_mask = 16'($urandom) | 16'($urandom);
				endcase
				for (int b = 0; b < 16; b++) begin
					out_ch.ready <= stall_mask[b];
					@(posedge clk);
				end
			end
		end
	end

	// monitor: register writes, result checks, expectations, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			active = 1'b0;
			if (cfg_write) begin
				active = 1'b1;
				case (cfg_index)
					REG_KERNEL_SIZES: kern_reg = cfg_data[KREG_W-1:0];
					REG_STRIDES:      stride_reg = cfg_data[KREG_W-1:0];
					REG_PADS:         pad_reg = cfg_data[KREG_W-1:0];
					REG_INPUT_DIMS:   in_dims_reg = cfg_data[DREG_W-1:0];
					REG_OUTPUT_DIMS:  out_dims_reg = cfg_data[DREG_W-1:0];
					REG_PLANE_COUNT:  planes_reg = cfg_data[PREG_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				active = 1'b1;
				seen_e = '{out_ch.dest_index, out_ch.source_address, out_ch.is_padding,
					out_ch.last};
				if (col_expect.size() == 0) begin
					flag($sformatf("result beat dest_index %0d with nothing expected",
						seen_e.dest_index));
				end else begin
					want_e = col_expect.pop_front();
					if (seen_e.dest_index !== want_e.dest_index)
						flag($sformatf("dest_index got %0d want %0d",
							seen_e.dest_index, want_e.dest_index));
					if (seen_e.source_address !== want_e.source_address)
						flag($sformatf("source_address got %0h want %0h (dest %0d)",
							seen_e.source_address, want_e.source_address, want_e.dest_index));
					if (seen_e.is_padding !== want_e.is_padding)
						flag($sformatf("is_padding got %b want %b (dest %0d)",
							seen_e.is_padding, want_e.is_padding, want_e.dest_index));
					if (seen_e.last !== want_e.last)
						flag($sformatf("last got %b want %b (dest %0d)",
							seen_e.last, want_e.last, want_e.dest_index));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				active = 1'b1;
				want_e = next_element(in_ch.restart);
				if (beat_plans.size() == 0) begin
					flag("input beat taken with no item offered");
				end else begin
					plan_e = beat_plans.pop_front();
					if (plan_e.known)
						want_e = plan_e.want;
				end
				col_expect.push_back(want_e);
			end
			idle_cycles = active ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("vol2col_address_walker verification failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		int        gap_max, gap, burst, sent;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_KERNEL_SIZES;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.restart = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			known(1'b0, 32'd0, 32'd0, 1'b0, 1'b1),
			known(1'b1, 32'd0, 32'd0, 1'b0, 1'b1),
			// empty input volume: all padding
			wr(REG_INPUT_DIMS, '0),
			known(1'b0, 32'd0, 32'd0, 1'b1, 1'b1),
			// everything at its maximum
			wr(REG_KERNEL_SIZES, 'hFFF),
			wr(REG_STRIDES, 'hFFF),
			wr(REG_PADS, 'hFFF),
			wr(REG_INPUT_DIMS, '1),
			wr(REG_OUTPUT_DIMS, '1),
			wr(REG_PLANE_COUNT, 'h3FF),
			known(1'b1, 32'd0, 32'd0, 1'b1, 1'b0),
			beat(1'b0),
			beat(1'b0),
			wr(REG_PADS, '0),
			known(1'b1, 32'd0, 32'd0, 1'b0, 1'b0),
			beat(1'b0),
			beat(1'b0),
			// zero sizes behave as one
			wr(REG_KERNEL_SIZES, '0),
			wr(REG_OUTPUT_DIMS, '0),
			wr(REG_PLANE_COUNT, '0),
			known(1'b1, 32'd0, 32'd0, 1'b0, 1'b1),
			beat(1'b0),
			// zero stride, then output width shrunk mid-walk
			wr(REG_STRIDES, '0),
			wr(REG_KERNEL_SIZES, 'h003),
			wr(REG_OUTPUT_DIMS, 'd8),
			beat(1'b0), beat(1'b0), beat(1'b0), beat(1'b0), beat(1'b0),
			wr(REG_OUTPUT_DIMS, 'd2),
			beat(1'b0), beat(1'b0), beat(1'b0), beat(1'b0),
			// writes to unused indices are dropped
			wr(REG_SPARE_LO, '1),
			wr(REG_SPARE_HI, '0),
			beat(1'b0),
			beat(1'b0)
		};
		foreach (rows[r]) begin
			case (rows[r].kind)
				ROW_WRITE: begin
					drain();
					write_reg(rows[r].idx, rows[r].data);
				end
				ROW_BEAT: send_beat(rows[r].restart, 1'b0, '0);
				default: send_beat(rows[r].restart, 1'b1, rows[r].want);
			endcase
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case ($urandom_range(0, 7))
				0: begin
					// long walk over planes with big volumes: address wrap
					write_reg(REG_KERNEL_SIZES, 'h111);
					write_reg(REG_OUTPUT_DIMS, {10'd1, 10'd1, 10'd1});
					write_reg(REG_PLANE_COUNT, 'h3FF);
					write_reg(REG_INPUT_DIMS, CFG_DATA_W'($urandom));
					write_reg(REG_PADS,
						CFG_DATA_W'({pad_field(), pad_field(), pad_field()}));
				end
				1: begin
					foreach (ALL_IDX[i])
						write_reg(ALL_IDX[i], CFG_DATA_W'($urandom));
				end
				default: begin
					if ($urandom_range(0, 1))
						write_reg(REG_KERNEL_SIZES,
							CFG_DATA_W'({small_k(3), small_k(3), small_k(3)}));
					if ($urandom_range(0, 1))
						write_reg(REG_STRIDES,
							CFG_DATA_W'({small_k(3), small_k(3), small_k(3)}));
					if ($urandom_range(0, 1))
						write_reg(REG_PADS,
							CFG_DATA_W'({pad_field(), pad_field(), pad_field()}));
					if ($urandom_range(0, 1))
						write_reg(REG_INPUT_DIMS, {small_d(8), small_d(8), small_d(8)});
					if ($urandom_range(0, 1))
						write_reg(REG_OUTPUT_DIMS, {small_d(3), small_d(3), small_d(3)});
					if ($urandom_range(0, 1))
						write_reg(REG_PLANE_COUNT, CFG_DATA_W'(small_d(3)));
					if ($urandom_range(0, 5) == 0)
						write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
							CFG_DATA_W'($urandom));
				end
			endcase

			gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
			if (phase == HOLD_PHASE)
				hold_req = 1'b1;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
					send_beat($urandom_range(0, 39) == 0, 1'b0, '0);
					sent++;
				end
				gap = $urandom_range(0, gap_max);
				if (gap != 0) begin
					in_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("vol2col_address_walker verification clean");
		else
			$display("vol2col_address_walker verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/v2c_pkg.sv
rtl/v2c_in_if.sv
rtl/v2c_out_if.sv
rtl/v2c_cfg.sv
rtl/v2c_ctrl.sv
rtl/v2c_dpath.sv
rtl/vol2col_address_walker.sv
rtl/v2c_checker.sv
bench/testbench.sv
